/* hw/rtl/sexpr_token_lexer_macros.svh */
// assertion macros for the s-expression token lexer
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SEXLEX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SEXLEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sexlex_pkg.sv */
// shared types, constants and helper functions of the token lexer
`timescale 1ns / 1ps
`default_nettype none
package sexlex_pkg;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_STR   = 2'd2,
        KIND_ATOM  = 2'd3
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_ATOM    = 3'd1,
        MODE_STR     = 3'd2,
        MODE_ESC     = 3'd3,
        MODE_COMMENT = 3'd4
    } lex_mode_t;

    typedef struct packed {
        token_kind_t kind;
        logic        has_char;
        logic [7:0]  char_value;
        logic        first;
        logic        tlast;
        logic        unterm;
    } result_t;

    // one or two results caused by one request
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } cmd_t;

    function automatic result_t make_result(token_kind_t kind, logic has, logic [7:0] ch,
                                            logic first, logic tlast, logic unterm);
        result_t r;
        r.kind       = kind;
        r.has_char   = has;
        r.char_value = has ? ch : 8'h00;
        r.first      = first;
        r.tlast      = tlast;
        r.unterm     = unterm;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // {known, mapped byte}
    function automatic logic [8:0] map_escape(logic [7:0] c);
        logic [8:0] m;
        case (c)
            8'h6E:   m = {1'b1, 8'h0A};
            8'h74:   m = {1'b1, 8'h09};
            8'h72:   m = {1'b1, 8'h0D};
            8'h76:   m = {1'b1, 8'h0B};
            8'h62:   m = {1'b1, 8'h08};
            8'h5C:   m = {1'b1, 8'h5C};
            8'h22:   m = {1'b1, 8'h22};
            8'h27:   m = {1'b1, 8'h27};
            default: m = {1'b0, 8'h00};
        endcase
        return m;
    endfunction

    // result of a byte at a token start; only meaningful when starts_emit
    function automatic result_t start_result(logic [7:0] c);
        result_t r;
        if (c == CH_OPEN) begin
            r = make_result(KIND_OPEN, 1'b1, c, 1'b1, 1'b1, 1'b0);
        end else if (c == CH_CLOSE) begin
            r = make_result(KIND_CLOSE, 1'b1, c, 1'b1, 1'b1, 1'b0);
        end else if (c == CH_QUOTE) begin
            r = make_result(KIND_STR, 1'b0, c, 1'b1, 1'b0, 1'b0);
        end else begin
            r = make_result(KIND_ATOM, 1'b1, c, 1'b1, 1'b0, 1'b0);
        end
        return r;
    endfunction

    function automatic logic starts_emit(logic [7:0] c);
        return (c != CH_SEMI) && !is_ws(c);
    endfunction

    function automatic lex_mode_t start_mode(logic [7:0] c);
        lex_mode_t m;
        if (c == CH_SEMI) begin
            m = MODE_COMMENT;
        end else if (is_ws(c) || c == CH_OPEN || c == CH_CLOSE) begin
            m = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
            m = MODE_STR;
        end else begin
            m = MODE_ATOM;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sexlex_front.sv */
// front end: accepts bytes, tracks lexer mode and builds result commands
`timescale 1ns / 1ps
`default_nettype none
module sexlex_front
    import sexlex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       line_end,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            cmd
);

    lex_mode_t mode_reg;
    lex_mode_t mode_next;
    logic      accept;
    logic      emit;
    logic      tok_byte;
    logic [8:0] esc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && emit;
    assign tok_byte = (char_code == CH_OPEN) || (char_code == CH_CLOSE)
                      || (char_code == CH_QUOTE);
    assign esc      = map_escape(char_code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    // next mode
    always_comb
    begin
        mode_next = MODE_IDLE;
        if (!line_end)
        begin
            case (mode_reg)
                MODE_COMMENT: mode_next = MODE_COMMENT;
                MODE_ESC:     mode_next = MODE_STR;
                MODE_STR:
                begin
                    if (char_code == CH_QUOTE)       mode_next = MODE_IDLE;
                    else if (char_code == CH_BSLASH) mode_next = MODE_ESC;
                    else                             mode_next = MODE_STR;
                end
                MODE_ATOM:
                begin
                    if (is_ws(char_code))  mode_next = MODE_IDLE;
                    else if (tok_byte)     mode_next = start_mode(char_code);
                    else                   mode_next = MODE_ATOM;
                end
                default:      mode_next = start_mode(char_code);
            endcase
        end
    end

    // results caused by this request
    always_comb
    begin
        cmd.two = 1'b0;
        cmd.r0  = make_result(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        cmd.r1  = make_result(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        emit    = 1'b0;
        if (line_end)
        begin
            case (mode_reg)
                MODE_ATOM:
                begin
                    cmd.r0 = make_result(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                    emit   = 1'b1;
                end
                MODE_STR, MODE_ESC:
                begin
                    cmd.r0 = make_result(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
                    emit   = 1'b1;
                end
                default: emit = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT: emit = 1'b0;
                MODE_ESC:
                begin
                    emit = 1'b1;
                    if (esc[8])
                    begin
                        cmd.r0 = make_result(KIND_STR, 1'b1, esc[7:0], 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        // unknown escape keeps the backslash and the byte
                        cmd.two = 1'b1;
                        cmd.r0  = make_result(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0);
                        cmd.r1  = make_result(KIND_STR, 1'b1, char_code, 1'b0, 1'b0, 1'b0);
                    end
                end
                MODE_STR:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        cmd.r0 = make_result(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        emit   = 1'b1;
                    end
                    else if (char_code != CH_BSLASH)
                    begin
                        cmd.r0 = make_result(KIND_STR, 1'b1, char_code, 1'b0, 1'b0, 1'b0);
                        emit   = 1'b1;
                    end
                end
                MODE_ATOM:
                begin
                    emit = 1'b1;
                    if (is_ws(char_code))
                    begin
                        cmd.r0 = make_result(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                    end
                    else if (tok_byte)
                    begin
                        cmd.two = 1'b1;
                        cmd.r0  = make_result(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        cmd.r1  = start_result(char_code);
                    end
                    else
                    begin
                        cmd.r0 = make_result(KIND_ATOM, 1'b1, char_code, 1'b0, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    cmd.r0 = start_result(char_code);
                    emit   = starts_emit(char_code);
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sexlex_queue.sv */
// short command queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module sexlex_queue
    import sexlex_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

    cmd_t              store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sexlex_back.sv */
// back end: walks each command out one result per cycle into the output register while out_ready lets it
`timescale 1ns / 1ps
`default_nettype none
module sexlex_back
    import sexlex_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      head,
    input  wire logic q_empty,
    output logic      pop,
    input  wire logic out_ready,
    output logic      out_valid,
    output result_t   out_res,
    output logic      out_last
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    half_reg;
    logic    half_next;
    result_t res_reg;
    logic    last_reg;
    logic    load;
    logic    sel_last;
    result_t sel;

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        load     = !q_empty && (!out_valid_reg || out_ready);
        sel      = half_reg ? head.r1 : head.r0;
        sel_last = half_reg || !head.two;
        pop      = load && sel_last;
        half_next = half_reg;
        if (load)
        begin
            half_next = !half_reg && head.two;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= sel;
            last_reg <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sexpr_token_lexer.sv */
// top level of the s-expression token lexer
// the first result of a request passes through the command queue and then the output register
// throughput: one request per cycle while the two-entry command queue has room
// the output register issues one result per cycle while out_ready lets it, so a two-result request issues them in turn
// reset: asynchronous, active low; mode returns to idle, queue and output register empty
`timescale 1ns / 1ps
`default_nettype none
`include "sexpr_token_lexer_macros.svh"
module sexpr_token_lexer
    import sexlex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       line_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      token_kind,
    output logic            has_char,
    output logic [7:0]      char_value,
    output logic            token_first,
    output logic            token_last,
    output logic            unterminated,
    output logic            last
);

    // front to queue
    logic    push;
    cmd_t    push_cmd;
    logic    q_full;
    // queue to back
    cmd_t    head;
    logic    q_empty;
    logic    pop;
    result_t out_res;

    // front end: classifies each request against the current lexer mode and
    // turns it into zero, one or two results packed as one command
    sexlex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .line_end  (line_end),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // decouples the two sides so either can stall alone
    sexlex_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end: streams each command out, marking the final result of a request
    sexlex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (last)
    );

    // unpack the result register onto the output ports
    assign token_kind   = out_res.kind;
    assign has_char     = out_res.has_char;
    assign char_value   = out_res.char_value;
    assign token_first  = out_res.first;
    assign token_last   = out_res.tlast;
    assign unterminated = out_res.unterm;

    // an unterminated string closes a string token and carries no character
    `SEXLEX_ASSERT_IMP(a_unterm_closes_str, out_valid && unterminated,
        token_last && !has_char && token_kind == KIND_STR, "unterminated result malformed")
    // parentheses are complete single-character tokens
    `SEXLEX_ASSERT_IMP(a_paren_single,
        out_valid && (token_kind == KIND_OPEN || token_kind == KIND_CLOSE),
        has_char && token_first && token_last, "paren token not single")
    // a result with no character shows a zero byte
    `SEXLEX_ASSERT_IMP(a_no_char_zero, out_valid && !has_char, char_value == 8'h00,
        "char_value set without has_char")
    // the front may only push when the queue has room
    `SEXLEX_ASSERT_IMP(a_push_room, push, !q_full, "push into full queue")

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench of the s-expression token lexer
`timescale 1ns / 1ps
module tb_top;
    import sexlex_pkg::*;

    // random requests after the directed table; no new line starts once this many are sent
    localparam int RANDOM_ITEMS = 1200;
    // the limit leaves room for a correct run, even with the heavy receiver stall
    localparam int CYCLE_LIMIT  = 400000;
    // the drain starts once every expected beat is seen, so a short drain is plenty
    localparam int DRAIN_CYCLES = 20;

    // the escape letters that map to a single byte inside a string
    localparam logic [7:0] ESC_LETTERS [8] = '{
        8'h6E, 8'h74, 8'h72, 8'h76, 8'h62, 8'h5C, 8'h22, 8'h27
    };

    // one output beat of the token stream, with the end-of-request mark
    typedef struct packed {
        token_kind_t kind;
        logic        has_char;
        logic [7:0]  char_value;
        logic        first;
        logic        tlast;
        logic        unterm;
        logic        lastf;
    } token_beat_t;

    localparam token_beat_t NO_BEAT = '0;

    // one row of the directed table; typed_n < 0 means the lexer model supplies the beats
    typedef struct {
        logic        le;
        logic [7:0]  code;
        int          typed_n;
        token_beat_t r0;
        token_beat_t r1;
    } request_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_code;
    logic       line_end;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] token_kind;
    logic       has_char;
    logic [7:0] char_value;
    logic       token_first;
    logic       token_last;
    logic       unterminated;
    logic       last;

    // lexer model state and the beats it predicts
    lex_mode_t     word_mode;
    token_beat_t   fresh_beats[$];
    token_beat_t   expected_beats[$];
    request_row_t  directed_rows[$];

    int mismatches  = 0;
    int random_sent = 0;
    int cycle_count = 0;
    int send_gap    = 9;
    int recv_stall  = 83;

    sexpr_token_lexer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .has_char     (has_char),
        .char_value   (char_value),
        .token_first  (token_first),
        .token_last   (token_last),
        .unterminated (unterminated),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // lexer model
    // ---------------------------------------------------------------

    // space, and tab through carriage return
    function automatic logic blank_byte(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic token_beat_t beat(input token_kind_t kind, input logic has,
                                         input logic [7:0] ch, input logic first,
                                         input logic tlast, input logic unterm,
                                         input logic lastf);
        token_beat_t b;
        b.kind       = kind;
        b.has_char   = has;
        b.char_value = has ? ch : 8'h00;
        b.first      = first;
        b.tlast      = tlast;
        b.unterm     = unterm;
        b.lastf      = lastf;
        return b;
    endfunction

    function automatic void emit(input token_kind_t kind, input logic has, input logic [7:0] ch,
                                 input logic first, input logic tlast, input logic unterm);
        fresh_beats.push_back(beat(kind, has, ch, first, tlast, unterm, 1'b0));
    endfunction

    // byte seen where a new token may begin
    function automatic void open_token(input logic [7:0] c);
        if (c == CH_SEMI)
        begin
            word_mode = MODE_COMMENT;
        end
        else if (blank_byte(c))
        begin
            word_mode = MODE_IDLE;
        end
        else if (c == CH_OPEN)
        begin
            emit(KIND_OPEN, 1'b1, c, 1'b1, 1'b1, 1'b0);
            word_mode = MODE_IDLE;
        end
        else if (c == CH_CLOSE)
        begin
            emit(KIND_CLOSE, 1'b1, c, 1'b1, 1'b1, 1'b0);
            word_mode = MODE_IDLE;
        end
        else if (c == CH_QUOTE)
        begin
            emit(KIND_STR, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
            word_mode = MODE_STR;
        end
        else
        begin
            emit(KIND_ATOM, 1'b1, c, 1'b1, 1'b0, 1'b0);
            word_mode = MODE_ATOM;
        end
    endfunction

    // {known, byte} for the character after a backslash
    function automatic logic [8:0] unescape(input logic [7:0] c);
        case (c)
            8'h6E:   return {1'b1, 8'h0A};
            8'h74:   return {1'b1, 8'h09};
            8'h72:   return {1'b1, 8'h0D};
            8'h76:   return {1'b1, 8'h0B};
            8'h62:   return {1'b1, 8'h08};
            8'h5C:   return {1'b1, 8'h5C};
            8'h22:   return {1'b1, 8'h22};
            8'h27:   return {1'b1, 8'h27};
            default: return {1'b0, 8'h00};
        endcase
    endfunction

    // advance the model by one request, leaving its beats in fresh_beats
    function automatic void lex_predict(input logic le, input logic [7:0] c);
        logic [8:0] esc;
        fresh_beats.delete();
        if (le)
        begin
            if (word_mode == MODE_ATOM)
                emit(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
            else if (word_mode == MODE_STR || word_mode == MODE_ESC)
                emit(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
            word_mode = MODE_IDLE;
        end
        else
        begin
            case (word_mode)
                MODE_COMMENT:
                begin
                    word_mode = MODE_COMMENT;
                end
                MODE_ESC:
                begin
                    esc = unescape(c);
                    if (esc[8])
                    begin
                        emit(KIND_STR, 1'b1, esc[7:0], 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        // unknown escape keeps the backslash and the byte
                        emit(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0);
                        emit(KIND_STR, 1'b1, c, 1'b0, 1'b0, 1'b0);
                    end
                    word_mode = MODE_STR;
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        word_mode = MODE_IDLE;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        word_mode = MODE_ESC;
                    end
                    else
                    begin
                        emit(KIND_STR, 1'b1, c, 1'b0, 1'b0, 1'b0);
                    end
                end
                MODE_ATOM:
                begin
                    if (blank_byte(c))
                    begin
                        emit(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        word_mode = MODE_IDLE;
                    end
                    else if (c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE)
                    begin
                        // atom closes, then the byte starts a token of its own
                        emit(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                        open_token(c);
                    end
                    else
                    begin
                        emit(KIND_ATOM, 1'b1, c, 1'b0, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    open_token(c);
                end
            endcase
        end
        if (fresh_beats.size() > 0)
            fresh_beats[fresh_beats.size() - 1].lastf = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // request side: called at a falling edge, returns at a falling edge
    // ---------------------------------------------------------------

    task automatic push_request(input request_row_t row);
        // random gap before the request; valid only drops while idling
        while ($urandom_range(0, 99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        line_end  <= row.le;
        char_code <= row.code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge: the model moves on and the beats are queued
        lex_predict(row.le, row.code);
        if (row.typed_n < 0)
        begin
            foreach (fresh_beats[i])
                expected_beats.push_back(fresh_beats[i]);
        end
        else
        begin
            if (row.typed_n >= 1)
                expected_beats.push_back(row.r0);
            if (row.typed_n >= 2)
                expected_beats.push_back(row.r1);
        end
        @(negedge clk);
    endtask

    // random request checked by the model; also steps the idling phases
    task automatic send_free(input logic le, input logic [7:0] code);
        request_row_t row;
        if (random_sent < RANDOM_ITEMS / 3)
        begin
            send_gap   = 9;
            recv_stall = 83;
        end
        else if (random_sent < 2 * RANDOM_ITEMS / 3)
        begin
            send_gap   = 83;
            recv_stall = 9;
        end
        else
        begin
            send_gap   = 0;
            recv_stall = 0;
        end
        row.le      = le;
        row.code    = code;
        row.typed_n = -1;
        row.r0      = NO_BEAT;
        row.r1      = NO_BEAT;
        random_sent++;
        push_request(row);
    endtask

    function automatic void add_row(input logic le, input logic [7:0] code, input int n,
                                    input token_beat_t r0, input token_beat_t r1);
        request_row_t row;
        row.le      = le;
        row.code    = code;
        row.typed_n = n;
        row.r0      = r0;
        row.r1      = r1;
        directed_rows.push_back(row);
    endfunction

    // any byte that may sit inside an atom; a semicolon cannot open one
    function automatic logic [7:0] atom_byte(input logic lead);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (blank_byte(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE
               || (lead && c == CH_SEMI));
        return c;
    endfunction

    // string content without quote or backslash
    function automatic logic [7:0] plain_str_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? 8'h20 : 8'(8 + k);
    endfunction

    // one text line: mostly well-formed tokens, some noise, some broken strings
    task automatic send_line();
        int  n_tok;
        int  t;
        logic open_str;
        open_str = 1'b0;
        n_tok    = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0)
        begin
            // noise, with line ends scattered through it
            repeat ($urandom_range(1, 12))
                send_free($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end
        else
        begin
            for (t = 0; t < n_tok && !open_str; t++)
            begin
                case ($urandom_range(0, 5))
                    0: send_free(1'b0, CH_OPEN);
                    1: send_free(1'b0, CH_CLOSE);
                    2, 3:
                    begin
                        send_free(1'b0, atom_byte(1'b1));
                        repeat ($urandom_range(0, 5))
                            send_free(1'b0, atom_byte(1'b0));
                    end
                    default:
                    begin
                        send_free(1'b0, CH_QUOTE);
                        repeat ($urandom_range(0, 6))
                        begin
                            if ($urandom_range(0, 4) == 0)
                            begin
                                send_free(1'b0, CH_BSLASH);
                                if ($urandom_range(0, 2) != 0)
                                    send_free(1'b0, ESC_LETTERS[3'($urandom_range(0, 7))]);
                                else
                                    send_free(1'b0, 8'($urandom_range(0, 255)));
                            end
                            else
                            begin
                                send_free(1'b0, plain_str_byte());
                            end
                        end
                        // now and then the string is left open to the line end
                        if ($urandom_range(0, 9) == 0)
                        begin
                            open_str = 1'b1;
                            if ($urandom_range(0, 1) == 0)
                                send_free(1'b0, CH_BSLASH);
                        end
                        else
                        begin
                            send_free(1'b0, CH_QUOTE);
                        end
                    end
                endcase
                if (!open_str)
                    repeat ($urandom_range(0, 2))
                        send_free(1'b0, blank_pick());
            end
            if (!open_str && $urandom_range(0, 4) == 0)
            begin
                send_free(1'b0, CH_SEMI);
                repeat ($urandom_range(0, 6))
                    send_free(1'b0, 8'($urandom_range(0, 255)));
            end
            send_free(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        in_valid  = 1'b0;
        char_code = 8'h00;
        line_end  = 1'b0;
        rst_n     = 1'b0;
        word_mode = MODE_IDLE;

        // directed table: parens, byte extremes, escapes, unterminated string, comment
        add_row(1'b0, CH_OPEN, 1,
                beat(KIND_OPEN, 1'b1, CH_OPEN, 1'b1, 1'b1, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, CH_CLOSE, 1,
                beat(KIND_CLOSE, 1'b1, CH_CLOSE, 1'b1, 1'b1, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, 8'h00, 1,
                beat(KIND_ATOM, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, 8'hFF, 1,
                beat(KIND_ATOM, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, 8'h20, 1,
                beat(KIND_ATOM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, CH_QUOTE, 1,
                beat(KIND_STR, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, CH_BSLASH, 0, NO_BEAT, NO_BEAT);
        add_row(1'b0, 8'h6E, 1,
                beat(KIND_STR, 1'b1, 8'h0A, 1'b0, 1'b0, 1'b0, 1'b1), NO_BEAT);
        add_row(1'b0, CH_BSLASH, 0, NO_BEAT, NO_BEAT);
        // unknown escape gives the backslash and the byte
        add_row(1'b0, 8'h71, 2, beat(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0),
                beat(KIND_STR, 1'b1, 8'h71, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(1'b0, CH_BSLASH, 0, NO_BEAT, NO_BEAT);
        // line end straight after a backslash: string flagged unterminated
        add_row(1'b1, 8'hFF, 1,
                beat(KIND_STR, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1), NO_BEAT);
        add_row(1'b0, CH_SEMI, 0, NO_BEAT, NO_BEAT);
        add_row(1'b0, CH_OPEN, 0, NO_BEAT, NO_BEAT);
        add_row(1'b1, 8'h00, 0, NO_BEAT, NO_BEAT);
        // semicolon inside an atom, then atoms closed by a paren and by a quote
        add_row(1'b0, 8'h61, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, CH_SEMI, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, CH_OPEN, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, 8'h78, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, CH_QUOTE, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, 8'hFF, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, CH_QUOTE, -1, NO_BEAT, NO_BEAT);
        add_row(1'b0, 8'h09, -1, NO_BEAT, NO_BEAT);
        // atom closed by the line end, then a line end with nothing open
        add_row(1'b0, 8'h7A, -1, NO_BEAT, NO_BEAT);
        add_row(1'b1, 8'hFF, -1, NO_BEAT, NO_BEAT);
        add_row(1'b1, 8'h00, -1, NO_BEAT, NO_BEAT);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            push_request(directed_rows[i]);

        while (random_sent < RANDOM_ITEMS)
            send_line();
        in_valid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random stall per cycle, as the phase asks
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall);

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    // every accepted beat is matched against the oldest expectation
    always @(posedge clk)
    begin : check_beats
        token_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("token beat with none expected: kind %0d char %0h",
                       token_kind, char_value);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                compare_field("token_kind", 8'(want.kind), 8'(token_kind));
                compare_field("has_char", 8'(want.has_char), 8'(has_char));
                compare_field("char_value", want.char_value, char_value);
                compare_field("token_first", 8'(want.first), 8'(token_first));
                compare_field("token_last", 8'(want.tlast), 8'(token_last));
                compare_field("unterminated", 8'(want.unterm), 8'(unterminated));
                compare_field("last", 8'(want.lastf), 8'(last));
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
